// ----- sv/ffa_pkg.sv -----
`timescale 1ns / 1ps
package ffa_pkg;

   localparam int EXT_N = 16;
   localparam int EXT_IW = 4;
   localparam int CNT_W = 5;
   localparam int REC_N = 16;
   localparam int REC_IW = 4;
   localparam int OFF_W = 16;
   localparam int LEN_W = 16;
   localparam int ADJ_W = 13;
   localparam int ALOG_W = 4;
   localparam int ALIGN_MAX = 12;
   localparam int WORD_BYTES = 8;
   localparam int HEADER_BYTES = 8;
   localparam logic [LEN_W-1:0] POOL_RESET = 16'd4096;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT
   } cell_op_type;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] length;
   } extent_type;

   typedef struct packed {
      cell_op_type op;
      extent_type  data;
   } cell_cmd_type;

   typedef struct packed {
      logic              clear_all;
      logic              set;
      logic              drop;
      logic [REC_IW-1:0] idx;
      logic [OFF_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic [ADJ_W-1:0]  adjust;
   } rec_cmd_type;

   typedef struct packed {
      logic              match_hit;
      logic [REC_IW-1:0] match_idx;
      logic              slot_hit;
      logic [REC_IW-1:0] slot_idx;
      logic [LEN_W-1:0]  length;
      logic [ADJ_W-1:0]  adjust;
   } rec_info_type;

endpackage

// ----- sv/ffa_cell.sv -----
`timescale 1ns / 1ps
module ffa_cell (
   input  logic                  clock,
   input  ffa_pkg::cell_cmd_type cmd,
   input  ffa_pkg::extent_type   left_data,
   input  ffa_pkg::extent_type   right_data,
   output ffa_pkg::extent_type   data
);

   ffa_pkg::extent_type data_ff;
   ffa_pkg::extent_type data_in;

   always_comb begin
      case (cmd.op)
         ffa_pkg::CELL_HOLD:       data_in = data_ff;
         ffa_pkg::CELL_LOAD:       data_in = cmd.data;
         ffa_pkg::CELL_TAKE_LEFT:  data_in = left_data;
         ffa_pkg::CELL_TAKE_RIGHT: data_in = right_data;
         default:                  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- sv/ffa_records.sv -----
`timescale 1ns / 1ps
module ffa_records (
   input  logic                             clock,
   input  logic                             reset,
   input  ffa_pkg::rec_cmd_type             cmd,
   input  logic [ffa_pkg::OFF_W-1:0]        lookup_offset,
   output ffa_pkg::rec_info_type            info,
   output logic [ffa_pkg::REC_N-1:0]        valid_bits
);

   logic [ffa_pkg::OFF_W-1:0] offset_ff [ffa_pkg::REC_N];
   logic [ffa_pkg::LEN_W-1:0] length_ff [ffa_pkg::REC_N];
   logic [ffa_pkg::ADJ_W-1:0] adjust_ff [ffa_pkg::REC_N];
   logic [ffa_pkg::REC_N-1:0] valid_ff;
   logic [ffa_pkg::REC_N-1:0] valid_in;

   // Lowest matching entry and lowest free entry win, scanning downwards.
   always_comb begin
      info = '0;
      for (int i = ffa_pkg::REC_N - 1; i >= 0; i--) begin
         if (valid_ff[i] && offset_ff[i] == lookup_offset) begin
            info.match_hit = 1'b1;
            info.match_idx = ffa_pkg::REC_IW'(i);
         end
         if (!valid_ff[i]) begin
            info.slot_hit = 1'b1;
            info.slot_idx = ffa_pkg::REC_IW'(i);
         end
      end
      info.length = length_ff[info.match_idx];
      info.adjust = adjust_ff[info.match_idx];
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.set) begin
         valid_in[cmd.idx] = 1'b1;
      end else if (cmd.drop) begin
         valid_in[cmd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set && !cmd.clear_all) begin
         offset_ff[cmd.idx] <= cmd.offset;
         length_ff[cmd.idx] <= cmd.length;
         adjust_ff[cmd.idx] <= cmd.adjust;
      end
   end

   assign valid_bits = valid_ff;

endmodule

// ----- sv/first_fit_free_list_allocator.sv -----
`timescale 1ns / 1ps
// First-fit pool allocator. The free extents sit in address order in a row of cells that
// shift left or right together to drop or insert an extent; allocation records are kept
// in a small table searched in parallel. One request is handled at a time: a request is
// taken in, looks up the record table, then visits the extents one by one in the first-fit
// or address-order scan, and posts the result; a full record table or an unknown offset
// skips the scan.
// Writing the pool size reinitialises the pool to one free extent and drops every record.
module first_fit_free_list_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [15:0]                       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [15:0]                       req_request_bytes,
   input  logic [3:0]                        req_align_log2,
   input  logic [15:0]                       req_release_offset,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_granted_offset,
   output logic [1:0]                        rsp_status_code,
   output logic [15:0]                       rsp_bytes_in_use,
   output logic [4:0]                        rsp_live_count
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOKUP = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   localparam int OW = ffa_pkg::OFF_W;
   localparam int LW = ffa_pkg::LEN_W;
   localparam int CW = ffa_pkg::CNT_W;

   state_type state_ff, state_in;
   logic          op_ff, op_in;
   logic [LW:0]   size_ff, size_in;
   logic [ffa_pkg::ALIGN_MAX-1:0] amask_ff, amask_in;
   logic [OW-1:0] off_ff, off_in;
   logic [ffa_pkg::REC_IW-1:0] slot_ff, slot_in;
   logic [ffa_pkg::REC_IW-1:0] rec_ff, rec_in;
   logic [OW-1:0] begin_ff, begin_in;
   logic [LW-1:0] flen_ff, flen_in;
   logic [OW:0]   fend_ff, fend_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   ffa_pkg::extent_type prev_ff, prev_in;
   logic [OW:0]   prev_end_ff, prev_end_in;
   logic [LW-1:0] used_ff, used_in;
   logic [CW-1:0] live_ff, live_in;
   logic [OW-1:0] res_off_ff, res_off_in;
   logic [1:0]    res_st_ff, res_st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_off_ff, rsp_off_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;
   logic [LW-1:0] rsp_used_ff, rsp_used_in;
   logic [CW-1:0] rsp_live_ff, rsp_live_in;

   ffa_pkg::cell_cmd_type cmds [ffa_pkg::EXT_N];
   ffa_pkg::extent_type   cells [ffa_pkg::EXT_N];
   ffa_pkg::rec_cmd_type  rcmd;
   ffa_pkg::rec_info_type rinfo;
   logic [ffa_pkg::REC_N-1:0] rvalid;

   ffa_pkg::extent_type cur;
   logic          in_range;
   logic [OW:0]   base;
   logic [ffa_pkg::ALIGN_MAX-1:0] pad;
   logic [ffa_pkg::ADJ_W-1:0] adj;
   logic [LW+1:0] body;
   logic [LW+1:0] rem;
   logic          fit;
   logic          whole;
   logic          stop;
   logic          mprev;
   logic          mnext;
   logic [ffa_pkg::ALIGN_MAX:0] amask_wide;
   logic [ffa_pkg::ALOG_W-1:0]  alog_c;
   logic [LW+1:0] size_raw;
   logic          accept;

   genvar g;
   generate
      for (g = 0; g < ffa_pkg::EXT_N; g++) begin : g_cell
         ffa_cell u_cell (
            .clock      (clock),
            .cmd        (cmds[g]),
            .left_data  (cells[(g == 0) ? 0 : g - 1]),
            .right_data (cells[(g == ffa_pkg::EXT_N - 1) ? g : g + 1]),
            .data       (cells[g])
         );
      end
   endgenerate

   ffa_records u_records (
      .clock         (clock),
      .reset         (reset),
      .cmd           (rcmd),
      .lookup_offset (off_ff),
      .info          (rinfo),
      .valid_bits    (rvalid)
   );

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      alog_c = (req_align_log2 > ffa_pkg::ALOG_W'(ffa_pkg::ALIGN_MAX)) ?
               ffa_pkg::ALOG_W'(ffa_pkg::ALIGN_MAX) : req_align_log2;
      amask_wide = ((ffa_pkg::ALIGN_MAX + 1)'(1) << alog_c) - (ffa_pkg::ALIGN_MAX + 1)'(1);
      size_raw = {2'b00, req_request_bytes} + (LW + 2)'(ffa_pkg::WORD_BYTES - 1);
      size_raw = size_raw & ~((LW + 2)'(ffa_pkg::WORD_BYTES - 1));

      cur = cells[idx_ff[ffa_pkg::EXT_IW-1:0]];
      in_range = idx_ff < cnt_ff;
      base = {1'b0, cur.start} + (OW + 1)'(ffa_pkg::HEADER_BYTES);
      pad = (ffa_pkg::ALIGN_MAX'(0) - base[ffa_pkg::ALIGN_MAX-1:0]) & amask_ff;
      adj = ffa_pkg::ADJ_W'(ffa_pkg::HEADER_BYTES) + {1'b0, pad};
      body = {1'b0, size_ff} + (LW + 2)'(adj);
      fit = in_range && ({2'b00, cur.length} >= body);
      rem = {2'b00, cur.length} - body;
      whole = rem <= (LW + 2)'(ffa_pkg::HEADER_BYTES);
      stop = !in_range || ({1'b0, cur.start} >= fend_ff);
      mprev = (idx_ff != '0) && (prev_end_ff == {1'b0, begin_ff});
      mnext = in_range && ({1'b0, cur.start} == fend_ff);
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      size_in = size_ff;
      amask_in = amask_ff;
      off_in = off_ff;
      slot_in = slot_ff;
      rec_in = rec_ff;
      begin_in = begin_ff;
      flen_in = flen_ff;
      fend_in = fend_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      prev_in = prev_ff;
      prev_end_in = prev_end_ff;
      used_in = used_ff;
      live_in = live_ff;
      res_off_in = res_off_ff;
      res_st_in = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_off_in = rsp_off_ff;
      rsp_st_in = rsp_st_ff;
      rsp_used_in = rsp_used_ff;
      rsp_live_in = rsp_live_ff;
      rcmd = '0;
      for (int k = 0; k < ffa_pkg::EXT_N; k++) begin
         cmds[k] = '{op: ffa_pkg::CELL_HOLD, data: '0};
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_operation;
               size_in = size_raw[LW:0];
               amask_in = amask_wide[ffa_pkg::ALIGN_MAX-1:0];
               off_in = req_release_offset;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            idx_in = '0;
            res_off_in = '0;
            if (op_ff == ffa_pkg::OP_ALLOC) begin
               slot_in = rinfo.slot_idx;
               if (rinfo.slot_hit) begin
                  state_in = S_SCAN;
               end else begin
                  res_st_in = ffa_pkg::STATUS_FULL;
                  state_in = S_DONE;
               end
            end else begin
               rec_in = rinfo.match_idx;
               flen_in = rinfo.length;
               begin_in = off_ff - OW'(rinfo.adjust);
               fend_in = {1'b0, begin_in} + {1'b0, rinfo.length};
               if (rinfo.match_hit) begin
                  state_in = S_SCAN;
               end else begin
                  res_st_in = ffa_pkg::STATUS_UNKNOWN;
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (op_ff == ffa_pkg::OP_ALLOC) begin
               if (!in_range) begin
                  res_st_in = ffa_pkg::STATUS_NOFIT;
                  state_in = S_DONE;
               end else if (fit) begin
                  if (whole) begin
                     for (int k = 0; k < ffa_pkg::EXT_N; k++) begin
                        if (CW'(k) >= idx_ff) cmds[k].op = ffa_pkg::CELL_TAKE_RIGHT;
                     end
                     cnt_in = cnt_ff - CW'(1);
                  end else begin
                     for (int k = 0; k < ffa_pkg::EXT_N; k++) begin
                        if (CW'(k) == idx_ff) begin
                           cmds[k].op = ffa_pkg::CELL_LOAD;
                           cmds[k].data.start = cur.start + body[OW-1:0];
                           cmds[k].data.length = rem[LW-1:0];
                        end
                     end
                  end
                  rcmd.set = 1'b1;
                  rcmd.idx = slot_ff;
                  rcmd.offset = cur.start + OW'(adj);
                  rcmd.length = whole ? cur.length : body[LW-1:0];
                  rcmd.adjust = adj;
                  used_in = used_ff + rcmd.length;
                  live_in = live_ff + CW'(1);
                  res_off_in = rcmd.offset;
                  res_st_in = ffa_pkg::STATUS_OK;
                  state_in = S_DONE;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               if (!stop) begin
                  prev_in = cur;
                  prev_end_in = {1'b0, cur.start} + {1'b0, cur.length};
                  idx_in = idx_ff + CW'(1);
               end else begin
                  res_st_in = ffa_pkg::STATUS_OK;
                  state_in = S_DONE;
                  if (!mprev && !mnext && cnt_ff >= CW'(ffa_pkg::EXT_N)) begin
                     res_st_in = ffa_pkg::STATUS_FULL;
                  end else begin
                     for (int k = 0; k < ffa_pkg::EXT_N; k++) begin
                        if (mprev && mnext) begin
                           if (CW'(k + 1) == idx_ff) begin
                              cmds[k].op = ffa_pkg::CELL_LOAD;
                              cmds[k].data.start = prev_ff.start;
                              cmds[k].data.length = prev_ff.length + flen_ff + cur.length;
                           end else if (CW'(k) >= idx_ff) begin
                              cmds[k].op = ffa_pkg::CELL_TAKE_RIGHT;
                           end
                        end else if (mprev) begin
                           if (CW'(k + 1) == idx_ff) begin
                              cmds[k].op = ffa_pkg::CELL_LOAD;
                              cmds[k].data.start = prev_ff.start;
                              cmds[k].data.length = prev_ff.length + flen_ff;
                           end
                        end else if (mnext) begin
                           if (CW'(k) == idx_ff) begin
                              cmds[k].op = ffa_pkg::CELL_LOAD;
                              cmds[k].data.start = begin_ff;
                              cmds[k].data.length = cur.length + flen_ff;
                           end
                        end else begin
                           if (CW'(k) == idx_ff) begin
                              cmds[k].op = ffa_pkg::CELL_LOAD;
                              cmds[k].data.start = begin_ff;
                              cmds[k].data.length = flen_ff;
                           end else if (CW'(k) > idx_ff) begin
                              cmds[k].op = ffa_pkg::CELL_TAKE_LEFT;
                           end
                        end
                     end
                     if (mprev && mnext) begin
                        cnt_in = cnt_ff - CW'(1);
                     end else if (!mprev && !mnext) begin
                        cnt_in = cnt_ff + CW'(1);
                     end
                     rcmd.drop = 1'b1;
                     rcmd.idx = rec_ff;
                     used_in = used_ff - flen_ff;
                     live_in = live_ff - CW'(1);
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_off_in = res_off_ff;
               rsp_st_in = res_st_ff;
               rsp_used_in = used_ff;
               rsp_live_in = live_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A pool size write, like reset, leaves one free extent covering the whole pool.
      if (reset || csr_wr_en) begin
         for (int k = 0; k < ffa_pkg::EXT_N; k++) begin
            cmds[k].op = ffa_pkg::CELL_HOLD;
         end
         cmds[0].op = ffa_pkg::CELL_LOAD;
         cmds[0].data.start = '0;
         cmds[0].data.length = reset ? ffa_pkg::POOL_RESET : csr_wr_data;
         rcmd = '0;
         rcmd.clear_all = 1'b1;
         cnt_in = CW'(1);
         used_in = '0;
         live_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= CW'(1);
         used_ff <= '0;
         live_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         used_ff <= used_in;
         live_ff <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      size_ff <= size_in;
      amask_ff <= amask_in;
      off_ff <= off_in;
      slot_ff <= slot_in;
      rec_ff <= rec_in;
      begin_ff <= begin_in;
      flen_ff <= flen_in;
      fend_ff <= fend_in;
      idx_ff <= idx_in;
      prev_ff <= prev_in;
      prev_end_ff <= prev_end_in;
      res_off_ff <= res_off_in;
      res_st_ff <= res_st_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff <= rsp_st_in;
      rsp_used_ff <= rsp_used_in;
      rsp_live_ff <= rsp_live_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_granted_offset = rsp_off_ff;
   assign rsp_status_code = rsp_st_ff;
   assign rsp_bytes_in_use = rsp_used_ff;
   assign rsp_live_count = rsp_live_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(ffa_pkg::EXT_N))
      else $error("extent count beyond table depth");

   a_live_matches_records: assert property (@(posedge clock) disable iff (reset)
      live_ff == CW'($countones(rvalid)))
      else $error("live count disagrees with record table");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result transfer raised outside completion");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> idx_ff <= cnt_ff)
      else $error("scan ran past the extent count");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

   localparam int IDLE_CYCLES = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic        op;
      logic [15:0] bytes;
      logic [3:0]  alog;
      logic [15:0] offset;
      bit          typed;
      logic [15:0] exp_granted;
      logic [1:0]  exp_status;
   } stim_row_type;

   typedef struct {
      logic [15:0] granted;
      logic [1:0]  status;
      logic [15:0] in_use;
      logic [4:0]  live;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = ffa_pkg::OP_ALLOC;
   logic [15:0] req_request_bytes = '0;
   logic [3:0] req_align_log2 = '0;
   logic [15:0] req_release_offset = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_granted_offset;
   logic [1:0] rsp_status_code;
   logic [15:0] rsp_bytes_in_use;
   logic [4:0] rsp_live_count;

   first_fit_free_list_allocator dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Shadow of the allocator state.
   logic [15:0] pool_size;
   logic [15:0] ext_start [ffa_pkg::EXT_N];
   logic [15:0] ext_len [ffa_pkg::EXT_N];
   int          ext_cnt;
   logic [15:0] rec_off [ffa_pkg::REC_N];
   logic [15:0] rec_len [ffa_pkg::REC_N];
   logic [12:0] rec_adj [ffa_pkg::REC_N];
   bit          rec_live [ffa_pkg::REC_N];
   logic [15:0] used_bytes;
   logic [4:0]  live_allocs;

   grant_type expected_grants[$];
   int failures = 0;
   int transfers_in = 0;
   int transfers_out = 0;
   int quiet_cycles = 0;
   bit quiet_phase = 0;
   int n_alloc_ok = 0, n_free_ok = 0, n_nofit = 0, n_full = 0, n_unknown = 0;

   function automatic void pool_clear(input logic [15:0] size);
      pool_size = size;
      for (int k = 0; k < ffa_pkg::EXT_N; k++) begin
         ext_start[k] = '0;
         ext_len[k] = '0;
      end
      for (int k = 0; k < ffa_pkg::REC_N; k++) rec_live[k] = 0;
      ext_len[0] = size;
      ext_cnt = 1;
      used_bytes = '0;
      live_allocs = '0;
   endfunction

   function automatic void drop_extent(input int idx);
      for (int k = idx; k + 1 < ext_cnt; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k] = ext_len[k+1];
      end
      ext_cnt--;
   endfunction

   function automatic grant_type serve_request(input logic op, input logic [15:0] bytes,
                                               input logic [3:0] alog_in,
                                               input logic [15:0] offset);
      grant_type g;
      int slot, r, i;
      longint size, align, s, len, adj, body, first, span, last;
      bit merge_lo, merge_hi, done;
      g.granted = '0;
      g.status = ffa_pkg::STATUS_NOFIT;
      if (op == ffa_pkg::OP_ALLOC) begin
         align = 64'd1 << ((alog_in > ffa_pkg::ALIGN_MAX) ? ffa_pkg::ALIGN_MAX : alog_in);
         size = ((longint'(bytes) + ffa_pkg::WORD_BYTES - 1) / ffa_pkg::WORD_BYTES)
                * ffa_pkg::WORD_BYTES;
         slot = -1;
         for (int k = ffa_pkg::REC_N - 1; k >= 0; k--) if (!rec_live[k]) slot = k;
         done = 0;
         if (slot < 0) g.status = ffa_pkg::STATUS_FULL;
         else begin
            for (i = 0; i < ext_cnt && !done; i++) begin
               s = ext_start[i];
               len = ext_len[i];
               adj = ffa_pkg::HEADER_BYTES
                     + ((align - ((s + ffa_pkg::HEADER_BYTES) & (align - 1))) & (align - 1));
               body = size + adj;
               if (len >= body) begin
                  if (len - body <= ffa_pkg::HEADER_BYTES) begin
                     body = len;
                     drop_extent(i);
                  end else begin
                     ext_start[i] = 16'(s + body);
                     ext_len[i] = 16'(len - body);
                  end
                  g.granted = 16'(s + adj);
                  g.status = ffa_pkg::STATUS_OK;
                  rec_live[slot] = 1;
                  rec_off[slot] = g.granted;
                  rec_len[slot] = 16'(body);
                  rec_adj[slot] = 13'(adj);
                  used_bytes = 16'(used_bytes + body);
                  live_allocs = live_allocs + 5'd1;
                  done = 1;
               end
            end
         end
      end else begin
         r = -1;
         for (int k = ffa_pkg::REC_N - 1; k >= 0; k--)
            if (rec_live[k] && rec_off[k] == offset) r = k;
         if (r < 0) g.status = ffa_pkg::STATUS_UNKNOWN;
         else begin
            span = rec_len[r];
            first = 16'(offset - rec_adj[r]);
            last = first + span;
            i = 0;
            while (i < ext_cnt && ext_start[i] < last) i++;
            merge_lo = i > 0 && (longint'(ext_start[i-1]) + ext_len[i-1] == first);
            merge_hi = i < ext_cnt && ext_start[i] == last;
            g.status = ffa_pkg::STATUS_OK;
            if (merge_lo && merge_hi) begin
               ext_len[i-1] = 16'(ext_len[i-1] + span + ext_len[i]);
               drop_extent(i);
            end else if (merge_lo) ext_len[i-1] = 16'(ext_len[i-1] + span);
            else if (merge_hi) begin
               ext_start[i] = 16'(first);
               ext_len[i] = 16'(ext_len[i] + span);
            end else if (ext_cnt >= ffa_pkg::EXT_N) g.status = ffa_pkg::STATUS_FULL;
            else begin
               for (int k = ext_cnt; k > i; k--) begin
                  ext_start[k] = ext_start[k-1];
                  ext_len[k] = ext_len[k-1];
               end
               ext_start[i] = 16'(first);
               ext_len[i] = 16'(span);
               ext_cnt++;
            end
            if (g.status == ffa_pkg::STATUS_OK) begin
               rec_live[r] = 0;
               used_bytes = 16'(used_bytes - span);
               live_allocs = live_allocs - 5'd1;
            end
         end
      end
      if (g.status != ffa_pkg::STATUS_OK) g.granted = '0;
      g.in_use = used_bytes;
      g.live = live_allocs;
      case (g.status)
         ffa_pkg::STATUS_OK: begin
            if (op == ffa_pkg::OP_ALLOC) n_alloc_ok++;
            else n_free_ok++;
         end
         ffa_pkg::STATUS_NOFIT: n_nofit++;
         ffa_pkg::STATUS_FULL: n_full++;
         default: n_unknown++;
      endcase
      return g;
   endfunction

   // Any live offset, used so that frees mostly hit real allocations.
   function automatic logic [15:0] pick_live_offset();
      int picks[$];
      for (int k = 0; k < ffa_pkg::REC_N; k++) if (rec_live[k]) picks.push_back(k);
      if (picks.size() == 0) return 16'($urandom);
      return rec_off[picks[$urandom_range(0, picks.size() - 1)]];
   endfunction

   // Result side: random stall and checking.
   always @(posedge clock) begin
      grant_type e;
      if (reset) rsp_stall <= 1'b0;
      else begin
         if (rsp_valid && !rsp_stall) begin
            transfers_out++;
            if (expected_grants.size() == 0) begin
               $error("unexpected transfer: granted_offset %0d", rsp_granted_offset);
               failures++;
            end else begin
               e = expected_grants.pop_front();
               if (rsp_granted_offset !== e.granted) begin
                  $error("granted_offset: expected %0d, got %0d", e.granted,
                         rsp_granted_offset);
                  failures++;
               end
               if (rsp_status_code !== e.status) begin
                  $error("status_code: expected %0d, got %0d", e.status, rsp_status_code);
                  failures++;
               end
               if (rsp_bytes_in_use !== e.in_use) begin
                  $error("bytes_in_use: expected %0d, got %0d", e.in_use, rsp_bytes_in_use);
                  failures++;
               end
               if (rsp_live_count !== e.live) begin
                  $error("live_count: expected %0d, got %0d", e.live, rsp_live_count);
                  failures++;
               end
            end
         end
         rsp_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 15);
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Valid stays high between back-to-back requests; it drops only for idle cycles.
   task automatic send_request(input logic op, input logic [15:0] bytes,
                               input logic [3:0] alog, input logic [15:0] offset,
                               input bit typed, input logic [15:0] exp_granted,
                               input logic [1:0] exp_status);
      grant_type g;
      while (!quiet_phase && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_request_bytes <= bytes;
      req_align_log2 <= alog;
      req_release_offset <= offset;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      transfers_in++;
      g = serve_request(op, bytes, alog, offset);
      if (typed && g.granted !== exp_granted) begin
         $error("directed row granted_offset: expected %0d, predicted %0d", exp_granted,
                g.granted);
         failures++;
      end
      if (typed && g.status !== exp_status) begin
         $error("directed row status_code: expected %0d, predicted %0d", exp_status,
                g.status);
         failures++;
      end
      if (typed) begin
         g.granted = exp_granted;
         g.status = exp_status;
      end
      expected_grants.push_back(g);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_pool(input logic [15:0] size);
      csr_wr_en <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pool_clear(size);
   endtask

   task automatic random_phase(input int count, input int max_bytes);
      logic [15:0] bytes;
      for (int n = 0; n < count; n++) begin
         quiet_phase = (n >= count / 2 && n < count / 2 + 30);
         case ($urandom_range(0, 19))
            0: send_request(ffa_pkg::OP_ALLOC, 16'($urandom), 4'($urandom), 16'($urandom),
                            0, 0, 0);
            1: send_request(ffa_pkg::OP_FREE, 16'($urandom), 4'($urandom), 16'($urandom),
                            0, 0, 0);
            2, 3, 4, 5, 6, 7, 8, 9: begin
               bytes = 16'($urandom_range(0, max_bytes));
               send_request(ffa_pkg::OP_ALLOC, bytes, 4'($urandom_range(0, 6)),
                            16'($urandom), 0, 0, 0);
            end
            default:
               send_request(ffa_pkg::OP_FREE, 16'($urandom), 4'($urandom),
                            pick_live_offset(), 0, 0, 0);
         endcase
      end
      quiet_phase = 0;
   endtask

   stim_row_type directed [] = '{
      // After reset the pool is 4096 bytes: first grant lands behind the header.
      '{ffa_pkg::OP_ALLOC, 16'd1,    4'd0,  16'd0,    1, 16'd8,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_ALLOC, 16'd0,    4'd0,  16'd0,    1, 16'd24, ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_ALLOC, 16'hFFFF, 4'd0,  16'd0,    1, 16'd0,  ffa_pkg::STATUS_NOFIT},
      '{ffa_pkg::OP_ALLOC, 16'd100,  4'd12, 16'd0,    0, 16'd0,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_ALLOC, 16'd17,   4'd15, 16'd0,    0, 16'd0,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_FREE,  16'd0,    4'd0,  16'hFFFF, 1, 16'd0,  ffa_pkg::STATUS_UNKNOWN},
      '{ffa_pkg::OP_FREE,  16'd0,    4'd0,  16'd8,    1, 16'd0,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_FREE,  16'd0,    4'd0,  16'd8,    1, 16'd0,  ffa_pkg::STATUS_UNKNOWN},
      '{ffa_pkg::OP_ALLOC, 16'd8,    4'd3,  16'd0,    0, 16'd0,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_FREE,  16'd0,    4'd0,  16'd24,   0, 16'd0,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_ALLOC, 16'd4000, 4'd1,  16'd0,    0, 16'd0,  ffa_pkg::STATUS_OK},
      '{ffa_pkg::OP_ALLOC, 16'd5,    4'd0,  16'd0,    0, 16'd0,  ffa_pkg::STATUS_OK}
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      pool_clear(ffa_pkg::POOL_RESET);
      @(posedge clock);
      quiet_phase = 1;
      foreach (directed[n])
         send_request(directed[n].op, directed[n].bytes, directed[n].alog,
                      directed[n].offset, directed[n].typed, directed[n].exp_granted,
                      directed[n].exp_status);
      quiet_phase = 0;
      drain();

      // Record table full: sixteen small grants, then one more.
      write_pool(16'hFFFF);
      for (int n = 0; n < ffa_pkg::REC_N; n++)
         send_request(ffa_pkg::OP_ALLOC, 16'd8, 4'd0, 16'd0, 0, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 16'd8, 4'd0, 16'd0, 1, 16'd0, ffa_pkg::STATUS_FULL);
      // Freeing every other grant fragments the table; the rest merge back.
      for (int n = 0; n < ffa_pkg::REC_N; n += 2)
         send_request(ffa_pkg::OP_FREE, 16'd0, 4'd0, 16'(8 + 16 * n), 0, 0, 0);
      for (int n = 1; n < ffa_pkg::REC_N; n += 2)
         send_request(ffa_pkg::OP_FREE, 16'd0, 4'd0, 16'(8 + 16 * n), 0, 0, 0);
      drain();

      // Smallest legal pool and a pool below it.
      write_pool(16'd17);
      send_request(ffa_pkg::OP_ALLOC, 16'd8, 4'd0, 16'd0, 1, 16'd8, ffa_pkg::STATUS_OK);
      send_request(ffa_pkg::OP_ALLOC, 16'd1, 4'd0, 16'd0, 1, 16'd0, ffa_pkg::STATUS_NOFIT);
      drain();
      write_pool(16'd9);
      send_request(ffa_pkg::OP_ALLOC, 16'd0, 4'd0, 16'd0, 0, 0, 0);
      send_request(ffa_pkg::OP_ALLOC, 16'd1, 4'd0, 16'd0, 1, 16'd0, ffa_pkg::STATUS_NOFIT);
      drain();

      write_pool(16'd600);
      random_phase(200, 64);
      drain();
      write_pool(16'hFFFF);
      random_phase(200, 6000);
      drain();
      write_pool(16'($urandom_range(17, 3000)));
      random_phase(200, 200);
      drain();

      $display("covered %0d requests: %0d grants, %0d frees, %0d no-fit, %0d full, %0d unknown",
               transfers_in, n_alloc_ok, n_free_ok, n_nofit, n_full, n_unknown);
      $display("pool sizes 9, 17, 600, 4096, 65535 and one random; %0d responses checked",
               transfers_out);
      if (failures == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/ffa_records.sv
sv/first_fit_free_list_allocator.sv
dv/testbench.sv
